// ===== hw/rtl/periodic_timer_table_unit_macros.svh =====
// assertion macros for the periodic timer table unit
// used by the top level only, no other dependencies
`ifndef PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptt_pkg.sv =====
// shared types and constants for the periodic timer table unit
// no dependencies
package ptt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W        = 4;
    localparam int TIME_W        = 32;
    localparam int TICK_W        = 16;
    localparam int MODE_W        = 3;
    localparam int KIND_W        = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_DEL   = 3'd2,
        MODE_REPL  = 3'd3,
        MODE_QUERY = 3'd4
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE      = 2'd0,
        KIND_EXPIRED   = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_FULL      = 2'd3
    } t_kind;

    typedef enum logic {
        ALU_ADD_SAT = 1'b0,
        ALU_SUB     = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_SCAN_LAST,
        S_FIRE_RD,
        S_FIRE_WB,
        S_ADD_FIND,
        S_ADD_WR,
        S_DEL,
        S_REPL,
        S_QRY_RD,
        S_QRY_WAIT,
        S_MISC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] tag;
    } t_entry;

endpackage

// ===== hw/rtl/periodic_timer_table_unit.sv =====
// top level of the periodic timer table unit: sequencer, valid bits, time, result register
// depends on ptt_pkg, ptt_alu, ptt_mem and periodic_timer_table_unit_macros.svh
//
// A table of TIMER_SLOTS timers with one input channel of commands and one output channel
// of result beats. The block takes one command at a time and holds o_stall high until the
// last beat of that command has been taken. Delete, replace and the spare modes pass
// through their own state to the output state; query reads the entry, waits for the
// registered read data and then presents its beat; add walks the valid bits one slot a
// cycle. A tick scans the table once per expiry and once more to find none, and a tick
// that reaches the cap of 16 expiries skips its final scan: every expiry round reads all
// entries through the single read port of the entry store and compares each deadline in
// the one shared adder, then reads the chosen entry and rewrites it with its reloaded
// deadline, or frees it when its period is zero. Stalls on the output hold the block in
// its output state. Valid bits clear at reset, so no clearing pass is needed.
`include "periodic_timer_table_unit_macros.svh"

module periodic_timer_table_unit import ptt_pkg::*; #(
    parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_timer_slot,
    input  logic [TICK_W-1:0] i_tick_ms,
    input  logic [TIME_W-1:0] i_first_delay,
    input  logic [TIME_W-1:0] i_reload_period,
    input  logic [TIME_W-1:0] i_user_tag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [TIME_W-1:0] o_tag_out,
    output logic [TIME_W-1:0] o_now_ms,
    output logic              o_last
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

    t_state r_state, n_state;
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_fired;
    logic [TIME_W-1:0]      r_now;

    logic [MODE_W-1:0]    r_mode;
    logic [SLOT_W-1:0]    r_slot;
    logic [TICK_W-1:0]    r_tick;
    logic [TIME_W-1:0]    r_delay;
    logic [TIME_W-1:0]    r_period;
    logic [TIME_W-1:0]    r_tag;
    logic [IW-1:0]        r_idx;
    logic                 r_chk;
    logic [IW-1:0]        r_chk_idx;
    logic                 r_found;
    logic [IW-1:0]        r_best;
    logic [TIME_W-1:0]    r_best_dl;
    logic [RES_CNT_W-1:0] r_n;

    t_kind             r_out_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic [TIME_W-1:0] r_out_tag;
    logic              r_out_last;

    logic              in_acc;
    logic              last_acc;
    logic              cmd_beat;
    logic              any_valid;
    logic [IW-1:0]     slot_idx;
    logic              slot_ok;
    logic              entry_live;
    logic              cand;
    logic              last_fire;

    t_alu_op           alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_res;
    logic              alu_carry;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic [IW-1:0]     mem_raddr;
    t_entry            mem_rdata;

    ptt_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    ptt_mem #(
        .SLOTS (TIMER_SLOTS),
        .IDX_W (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign in_acc     = i_valid && !o_stall;
    assign o_valid    = (r_state == S_OUT);
    assign o_kind     = r_out_kind;
    assign o_slot_out = r_out_slot;
    assign o_tag_out  = r_out_tag;
    assign o_now_ms   = r_now;
    assign o_last     = r_out_last;

    assign last_acc   = o_valid && !i_stall && o_last;
    assign cmd_beat   = o_valid && (r_mode != MODE_TICK);

    assign any_valid  = |r_valid;
    assign slot_idx   = IW'(r_slot);
    assign slot_ok    = ({28'd0, r_slot} < 32'(TIMER_SLOTS)) && r_valid[slot_idx];
    assign entry_live = r_chk && r_valid[r_chk_idx] && !r_fired[r_chk_idx];
    assign last_fire  = (r_n + RES_CNT_W'(1)) == RES_CNT_W'(MAX_RESULTS);

    // datapath control
    always_comb begin
        alu_op    = ALU_ADD_SAT;
        alu_a     = r_now;
        alu_b     = '0;
        mem_raddr = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        cand      = 1'b0;
        unique case (r_state) inside
            S_TICK: begin
                alu_b = TIME_W'(r_tick);
            end
            S_SCAN, S_SCAN_LAST: begin
                alu_op = ALU_SUB;
                if (r_found) begin
                    alu_a = mem_rdata.deadline;
                    alu_b = r_best_dl;
                    cand  = entry_live && !alu_carry;
                end else begin
                    alu_a = r_now;
                    alu_b = mem_rdata.deadline;
                    cand  = entry_live && alu_carry;
                end
            end
            S_FIRE_RD: begin
                mem_raddr = r_best;
            end
            S_FIRE_WB: begin
                alu_b     = mem_rdata.period;
                mem_we    = (mem_rdata.period != '0);
                mem_waddr = r_best;
                mem_wdata = '{deadline: alu_res, period: mem_rdata.period,
                              tag: mem_rdata.tag};
            end
            S_ADD_WR: begin
                alu_b     = (r_delay != '0) ? r_delay : r_period;
                mem_we    = 1'b1;
                mem_wdata = '{deadline: alu_res, period: r_period, tag: r_tag};
            end
            S_REPL: begin
                alu_b     = r_delay;
                mem_we    = slot_ok;
                mem_waddr = slot_idx;
                mem_wdata = '{deadline: alu_res, period: r_period, tag: r_tag};
            end
            S_QRY_RD: begin
                mem_raddr = slot_idx;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_TICK:  n_state = S_TICK;
                        MODE_ADD:   n_state = S_ADD_FIND;
                        MODE_DEL:   n_state = S_DEL;
                        MODE_REPL:  n_state = S_REPL;
                        MODE_QUERY: n_state = S_QRY_RD;
                        default:    n_state = S_MISC;
                    endcase
                end
            end
            S_TICK: n_state = S_SCAN;
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST: begin
                if ((r_found || cand) && r_n == '0) begin
                    n_state = S_FIRE_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FIRE_RD: n_state = S_FIRE_WB;
            S_FIRE_WB: n_state = last_fire ? S_OUT : S_SCAN;
            S_ADD_FIND: begin
                if (!r_valid[r_idx]) begin
                    n_state = S_ADD_WR;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_OUT;
                end
            end
            S_QRY_RD: n_state = S_QRY_WAIT;
            S_ADD_WR, S_DEL, S_REPL, S_QRY_WAIT, S_MISC: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = r_out_last ? S_IDLE : S_FIRE_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_TICK: r_now <= any_valid ? alu_res : '0;
                S_FIRE_WB: begin
                    if (mem_rdata.period == '0) begin
                        r_valid[r_best] <= 1'b0;
                    end
                end
                S_ADD_WR: r_valid[r_idx] <= 1'b1;
                S_DEL: begin
                    if (slot_ok) begin
                        r_valid[slot_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // command, scan and result registers
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            S_IDLE: begin
                if (in_acc) begin
                    r_mode   <= i_mode;
                    r_slot   <= i_timer_slot;
                    r_tick   <= i_tick_ms;
                    r_delay  <= i_first_delay;
                    r_period <= i_reload_period;
                    r_tag    <= i_user_tag;
                    r_idx    <= '0;
                end
            end
            S_TICK: begin
                r_fired <= '0;
                r_n     <= '0;
                r_idx   <= '0;
                r_chk   <= 1'b0;
                r_found <= 1'b0;
            end
            S_SCAN, S_SCAN_LAST: begin
                if (cand) begin
                    r_found   <= 1'b1;
                    r_best    <= r_chk_idx;
                    r_best_dl <= mem_rdata.deadline;
                end
                if (r_state == S_SCAN) begin
                    r_chk     <= 1'b1;
                    r_chk_idx <= r_idx;
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end else if (!(r_found || cand)) begin
                    r_out_last <= 1'b1;
                    if (r_n == '0) begin
                        r_out_kind <= KIND_DONE;
                        r_out_slot <= '0;
                        r_out_tag  <= '0;
                    end
                end else begin
                    // another expiry follows, so any beat already held is not the last
                    r_out_last <= 1'b0;
                end
            end
            S_FIRE_WB: begin
                r_fired[r_best] <= 1'b1;
                r_n             <= r_n + RES_CNT_W'(1);
                r_out_kind      <= KIND_EXPIRED;
                r_out_slot      <= SLOT_W'(r_best);
                r_out_tag       <= mem_rdata.tag;
                r_out_last      <= last_fire;
                r_idx           <= '0;
                r_chk           <= 1'b0;
                r_found         <= 1'b0;
            end
            S_ADD_FIND: begin
                if (r_valid[r_idx]) begin
                    if (r_idx == LAST_IDX) begin
                        r_out_kind <= KIND_FULL;
                        r_out_slot <= '0;
                        r_out_tag  <= '0;
                        r_out_last <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end
            S_ADD_WR: begin
                r_out_kind <= KIND_DONE;
                r_out_slot <= SLOT_W'(r_idx);
                r_out_tag  <= '0;
                r_out_last <= 1'b1;
            end
            S_DEL, S_REPL: begin
                r_out_kind <= slot_ok ? KIND_DONE : KIND_NOT_FOUND;
                r_out_slot <= r_slot;
                r_out_tag  <= '0;
                r_out_last <= 1'b1;
            end
            S_QRY_WAIT: begin
                r_out_kind <= slot_ok ? KIND_DONE : KIND_NOT_FOUND;
                r_out_slot <= r_slot;
                r_out_tag  <= slot_ok ? mem_rdata.tag : '0;
                r_out_last <= 1'b1;
            end
            S_MISC: begin
                r_out_kind <= KIND_DONE;
                r_out_slot <= '0;
                r_out_tag  <= '0;
                r_out_last <= 1'b1;
            end
            default: ;
        endcase
    end

    `PTT_ASSERT_SAME(a_busy_while_beat, i_clk, i_rst_n, o_valid, o_stall, "beat while ready")
    `PTT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_stall, "ready after accept")
    `PTT_ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n, last_acc, !o_stall, "busy after last")
    `PTT_ASSERT_SAME(a_single_beat_cmd, i_clk, i_rst_n, cmd_beat, o_last, "command beat not last")

endmodule

// ===== hw/rtl/ptt_alu.sv =====
// shared 32-bit adder: saturating add or subtract with carry out
// depends on ptt_pkg
module ptt_alu import ptt_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W-1:0] o_res,
    output logic              o_carry
);

    logic [TIME_W:0] sum;

    always_comb begin
        unique case (i_op)
            ALU_ADD_SAT: sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB:     sum = {1'b0, i_a} + {1'b0, ~i_b} + {{TIME_W{1'b0}}, 1'b1};
            default:     sum = '0;
        endcase
    end

    // carry on subtract means a >= b
    assign o_carry = sum[TIME_W];
    assign o_res   = (i_op == ALU_ADD_SAT && sum[TIME_W]) ? '1 : sum[TIME_W-1:0];

endmodule

// ===== hw/rtl/ptt_mem.sv =====
// timer entry store: deadline, period and tag per slot
// one write port, one read port with registered data; depends on ptt_pkg
module ptt_mem import ptt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/ptt_checker.sv =====
// result checker for the periodic timer table unit: watches both channels, keeps its own
// timer table, predicts every result beat and compares it field by field
// depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_checker import ptt_pkg::*; #(
    parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  logic              i_cmd_stall,
    input  logic [MODE_W-1:0] i_cmd_mode,
    input  logic [SLOT_W-1:0] i_cmd_slot,
    input  logic [TICK_W-1:0] i_cmd_tick_ms,
    input  logic [TIME_W-1:0] i_cmd_first_delay,
    input  logic [TIME_W-1:0] i_cmd_reload_period,
    input  logic [TIME_W-1:0] i_cmd_user_tag,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [KIND_W-1:0] i_res_kind,
    input  logic [SLOT_W-1:0] i_res_slot,
    input  logic [TIME_W-1:0] i_res_tag,
    input  logic [TIME_W-1:0] i_res_now,
    input  logic              i_res_last,
    output int                o_err_count,
    output int                o_outstanding,
    output int                o_cmd_count,
    output int                o_beat_count,
    output int                o_expiry_count
);

    localparam int NO_SLOT = -1;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] tag;
        logic [TIME_W-1:0] now;
        logic              last;
    } t_timer_beat;

    logic              slot_live     [TIMER_SLOTS];
    logic [TIME_W-1:0] slot_deadline [TIMER_SLOTS];
    logic [TIME_W-1:0] slot_period   [TIMER_SLOTS];
    logic [TIME_W-1:0] slot_tag      [TIMER_SLOTS];
    logic [TIME_W-1:0] clock_ms;

    t_timer_beat expected_beats[$];
    int err_total;
    int cmd_total;
    int beat_total;
    int expiry_total;

    initial begin
        err_total    = 0;
        cmd_total    = 0;
        beat_total   = 0;
        expiry_total = 0;
        clock_ms     = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
            slot_live[i] = 1'b0;
    end

    function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    task automatic push_beat(input t_kind kind, input int slot, input logic [TIME_W-1:0] tag,
                             input logic last);
        t_timer_beat b;
        b.kind = kind;
        b.slot = slot[SLOT_W-1:0];
        b.tag  = tag;
        b.now  = clock_ms;
        b.last = last;
        expected_beats.push_back(b);
    endtask

    // expiries go out earliest deadline first, lower slot on a tie
    task automatic run_tick(input logic [TICK_W-1:0] ms);
        logic fired [TIMER_SLOTS];
        logic any_live;
        logic found;
        int   best;
        int   fired_cnt;
        int   i;
        clock_ms = add_sat(clock_ms, {{(TIME_W-TICK_W){1'b0}}, ms});
        any_live = 1'b0;
        for (i = 0; i < TIMER_SLOTS; i++) begin
            fired[i] = 1'b0;
            if (slot_live[i])
                any_live = 1'b1;
        end
        if (!any_live)
            clock_ms = '0;
        fired_cnt = 0;
        found     = 1'b1;
        while (found && fired_cnt < MAX_RESULTS) begin
            found = 1'b0;
            best  = 0;
            for (i = 0; i < TIMER_SLOTS; i++) begin
                if (slot_live[i] && !fired[i] && slot_deadline[i] <= clock_ms) begin
                    if (!found || slot_deadline[i] < slot_deadline[best]) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                fired[best] = 1'b1;
                push_beat(KIND_EXPIRED, best, slot_tag[best], 1'b0);
                fired_cnt++;
                if (slot_period[best] != '0)
                    slot_deadline[best] = add_sat(clock_ms, slot_period[best]);
                else
                    slot_live[best] = 1'b0;
            end
        end
        if (fired_cnt == 0)
            push_beat(KIND_DONE, 0, '0, 1'b0);
        expected_beats[expected_beats.size() - 1].last = 1'b1;
    endtask

    task automatic predict_command();
        int free_slot;
        int s;
        free_slot = NO_SLOT;
        s         = int'(i_cmd_slot);
        cmd_total++;
        case (i_cmd_mode)
            MODE_TICK: begin
                run_tick(i_cmd_tick_ms);
            end
            MODE_ADD: begin
                for (int i = TIMER_SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        free_slot = i;
                if (free_slot == NO_SLOT) begin
                    push_beat(KIND_FULL, 0, '0, 1'b1);
                end else begin
                    slot_live[free_slot]     = 1'b1;
                    slot_period[free_slot]   = i_cmd_reload_period;
                    slot_tag[free_slot]      = i_cmd_user_tag;
                    slot_deadline[free_slot] = add_sat(clock_ms, (i_cmd_first_delay != '0) ?
                                                       i_cmd_first_delay : i_cmd_reload_period);
                    push_beat(KIND_DONE, free_slot, '0, 1'b1);
                end
            end
            MODE_DEL: begin
                if (s < TIMER_SLOTS && slot_live[s]) begin
                    slot_live[s] = 1'b0;
                    push_beat(KIND_DONE, s, '0, 1'b1);
                end else begin
                    push_beat(KIND_NOT_FOUND, s, '0, 1'b1);
                end
            end
            MODE_REPL: begin
                if (s < TIMER_SLOTS && slot_live[s]) begin
                    slot_period[s]   = i_cmd_reload_period;
                    slot_tag[s]      = i_cmd_user_tag;
                    slot_deadline[s] = add_sat(clock_ms, i_cmd_first_delay);
                    push_beat(KIND_DONE, s, '0, 1'b1);
                end else begin
                    push_beat(KIND_NOT_FOUND, s, '0, 1'b1);
                end
            end
            MODE_QUERY: begin
                if (s < TIMER_SLOTS && slot_live[s])
                    push_beat(KIND_DONE, s, slot_tag[s], 1'b1);
                else
                    push_beat(KIND_NOT_FOUND, s, '0, 1'b1);
            end
            default: begin
                push_beat(KIND_DONE, 0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        err_total++;
        $display("%0t ns  result beat %0d: %s got %0h want %0h",
                 $time, beat_total, what, got, want);
    endtask

    task automatic check_beat();
        t_timer_beat want;
        beat_total++;
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat, kind", TIME_W'(i_res_kind), '0);
        end else begin
            want = expected_beats.pop_front();
            if (want.kind == KIND_EXPIRED)
                expiry_total++;
            if (i_res_kind != want.kind)
                report_mismatch("kind", TIME_W'(i_res_kind), TIME_W'(want.kind));
            if (i_res_slot != want.slot)
                report_mismatch("slot", TIME_W'(i_res_slot), TIME_W'(want.slot));
            if (i_res_tag != want.tag)
                report_mismatch("tag", i_res_tag, want.tag);
            if (i_res_now != want.now)
                report_mismatch("now", i_res_now, want.now);
            if (i_res_last != want.last)
                report_mismatch("last", TIME_W'(i_res_last), TIME_W'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++)
                slot_live[i] = 1'b0;
            clock_ms = '0;
            expected_beats.delete();
        end else begin
            if (i_res_valid && !i_res_stall)
                check_beat();
            if (i_cmd_valid && !i_cmd_stall)
                predict_command();
        end
        o_err_count    <= err_total;
        o_outstanding  <= expected_beats.size();
        o_cmd_count    <= cmd_total;
        o_beat_count   <= beat_total;
        o_expiry_count <= expiry_total;
    end

endmodule

// ===== bench/testbench.sv =====
// top of the periodic timer table unit bench: clock, reset, command stimulus, result stalls
// and the verdict; depends on ptt_pkg, ptt_checker and the periodic_timer_table_unit RTL
`timescale 1ns / 1ps

module testbench;
    import ptt_pkg::*;

    localparam int TIMER_SLOTS      = SLOTS_DEFAULT;
    localparam int RANDOM_CMDS      = 260;
    localparam int MODE_SPARE_FIRST = 5;
    localparam int MODE_SPARE_LAST  = 7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [MODE_W-1:0] i_mode;
    logic [SLOT_W-1:0] i_timer_slot;
    logic [TICK_W-1:0] i_tick_ms;
    logic [TIME_W-1:0] i_first_delay;
    logic [TIME_W-1:0] i_reload_period;
    logic [TIME_W-1:0] i_user_tag;
    logic              o_valid;
    logic              i_stall;
    logic [KIND_W-1:0] o_kind;
    logic [SLOT_W-1:0] o_slot_out;
    logic [TIME_W-1:0] o_tag_out;
    logic [TIME_W-1:0] o_now_ms;
    logic              o_last;

    int chk_errors;
    int chk_outstanding;
    int chk_cmds;
    int chk_beats;
    int chk_expiries;

    logic calm;
    int   cmds_sent;

    periodic_timer_table_unit #(.TIMER_SLOTS(TIMER_SLOTS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_timer_slot   (i_timer_slot),
        .i_tick_ms      (i_tick_ms),
        .i_first_delay  (i_first_delay),
        .i_reload_period(i_reload_period),
        .i_user_tag     (i_user_tag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_slot_out     (o_slot_out),
        .o_tag_out      (o_tag_out),
        .o_now_ms       (o_now_ms),
        .o_last         (o_last)
    );

    ptt_checker #(.TIMER_SLOTS(TIMER_SLOTS)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_valid        (i_valid),
        .i_cmd_stall        (o_stall),
        .i_cmd_mode         (i_mode),
        .i_cmd_slot         (i_timer_slot),
        .i_cmd_tick_ms      (i_tick_ms),
        .i_cmd_first_delay  (i_first_delay),
        .i_cmd_reload_period(i_reload_period),
        .i_cmd_user_tag     (i_user_tag),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_res_kind         (o_kind),
        .i_res_slot         (o_slot_out),
        .i_res_tag          (o_tag_out),
        .i_res_now          (o_now_ms),
        .i_res_last         (o_last),
        .o_err_count        (chk_errors),
        .o_outstanding      (chk_outstanding),
        .o_cmd_count        (chk_cmds),
        .o_beat_count       (chk_beats),
        .o_expiry_count     (chk_expiries)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #12_000_000;
        $display("** periodic_timer_table_unit: FAILED **");
        $finish;
    end

    function automatic logic [TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        else if (r < 60)
            return $urandom_range(1, 80);
        else if (r < 80)
            return $urandom_range(81, 3000);
        else if (r < 90)
            return 32'hFFFF_FFFF - $urandom_range(0, 255);
        else
            return $urandom;
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return TICK_W'($urandom_range(1, 60));
        else if (r < 90)
            return TICK_W'($urandom_range(61, 3000));
        else
            return TICK_W'($urandom_range(0, 65535));
    endfunction

    // low slots are the ones that lowest-free allocation keeps live
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 9) < 7)
            return SLOT_W'($urandom_range(0, 7));
        else
            return SLOT_W'($urandom_range(0, 15));
    endfunction

    // called at a falling edge; returns at the falling edge after the command is taken
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                            input logic [TICK_W-1:0] tick, input logic [TIME_W-1:0] delay,
                            input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] tag);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode          = mode;
        i_timer_slot    = slot;
        i_tick_ms       = tick;
        i_first_delay   = delay;
        i_reload_period = period;
        i_user_tag      = tag;
        i_valid         = 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (mode < MODE_SPARE_FIRST)
            cmds_sent++;
        @(negedge i_clk);
    endtask

    // result side: random stall after every taken beat, none while calm
    initial begin
        int hold;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_stall = 1'b1;
                hold--;
            end else begin
                i_stall = 1'b0;
            end
            @(posedge i_clk);
            if (o_valid && !i_stall)
                hold = calm ? 0 : $urandom_range(0, 7);
        end
    end

    initial begin
        int                directed_cmds;
        int                ep;
        logic [TIME_W-1:0] per;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_mode          = MODE_TICK;
        i_timer_slot    = '0;
        i_tick_ms       = '0;
        i_first_delay   = '0;
        i_reload_period = '0;
        i_user_tag      = '0;
        calm            = 1'b0;
        cmds_sent       = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: time snaps back to zero
        send_cmd(MODE_TICK, 4'h0, 16'h0000, '0, '0, '0);
        send_cmd(MODE_TICK, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(MODE_QUERY, 4'h0, '0, '0, '0, '0);
        send_cmd(MODE_DEL, 4'hF, '0, '0, '0, '0);
        send_cmd(MODE_REPL, 4'hA, '0, 32'd7, 32'd9, 32'h1234_5678);
        // zero first delay falls back to the period
        send_cmd(MODE_ADD, 4'hF, '0, '0, 32'd100, 32'h1111_0000);
        send_cmd(MODE_ADD, 4'h0, '0, 32'd5, '0, 32'hA5A5_5A5A);
        send_cmd(MODE_ADD, 4'h0, '0, 32'd5, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_cmd(MODE_ADD, 4'h0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(MODE_QUERY, 4'h3, '0, '0, '0, '0);
        // tie on deadline, one-shot freed, reload saturates
        send_cmd(MODE_TICK, 4'h0, 16'd5, '0, '0, '0);
        send_cmd(MODE_TICK, 4'h0, 16'd100, '0, '0, '0);
        // replace with zero delay: due at once, no period fallback
        send_cmd(MODE_REPL, 4'h0, '0, '0, '0, 32'h0BAD_F00D);
        send_cmd(MODE_TICK, 4'h0, '0, '0, '0, '0);
        send_cmd(MODE_DEL, 4'h3, '0, '0, '0, '0);
        send_cmd(MODE_DEL, 4'h3, '0, '0, '0, '0);
        send_cmd(MODE_ADD, 4'h0, '0, '0, '0, 32'hCAFE_0001);
        send_cmd(MODE_QUERY, 4'h0, '0, '0, '0, '0);
        send_cmd(MODE_TICK, 4'h0, 16'd1, '0, '0, '0);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_cmd(MODE_W'(m), pick_slot(), pick_tick(), $urandom, $urandom, $urandom);
        directed_cmds = cmds_sent;

        while (cmds_sent - directed_cmds < RANDOM_CMDS) begin
            ep   = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            if (ep < 15) begin
                // fill the table, overflow it, then tick far enough to expire every timer these adds set
                repeat (TIMER_SLOTS + 1) begin
                    per = $urandom_range(0, 1) ? 32'($urandom_range(1, 50)) : '0;
                    send_cmd(MODE_ADD, pick_slot(), pick_tick(), $urandom_range(1, 40), per,
                             $urandom);
                end
                send_cmd(MODE_TICK, pick_slot(), 16'd2000, $urandom, $urandom, $urandom);
                send_cmd(MODE_TICK, pick_slot(), pick_tick(), $urandom, $urandom, $urandom);
            end else if (ep < 25) begin
                // drain every slot, then tick an empty table
                for (int s = 0; s < TIMER_SLOTS; s++)
                    send_cmd(MODE_DEL, SLOT_W'(s), pick_tick(), $urandom, $urandom, $urandom);
                send_cmd(MODE_TICK, pick_slot(), pick_tick(), $urandom, $urandom, $urandom);
            end else begin
                repeat (20) begin
                    ep = $urandom_range(0, 99);
                    if (ep < 30)
                        send_cmd(MODE_TICK, pick_slot(), pick_tick(), $urandom, $urandom,
                                 $urandom);
                    else if (ep < 55)
                        send_cmd(MODE_ADD, SLOT_W'($urandom), pick_tick(), pick_time(),
                                 pick_time(), $urandom);
                    else if (ep < 68)
                        send_cmd(MODE_DEL, pick_slot(), pick_tick(), $urandom, $urandom,
                                 $urandom);
                    else if (ep < 82)
                        send_cmd(MODE_REPL, pick_slot(), pick_tick(), pick_time(), pick_time(),
                                 $urandom);
                    else if (ep < 96)
                        send_cmd(MODE_QUERY, pick_slot(), pick_tick(), $urandom, $urandom,
                                 $urandom);
                    else
                        send_cmd(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                                 SLOT_W'($urandom), TICK_W'($urandom), $urandom, $urandom,
                                 $urandom);
                end
            end
        end
        i_valid = 1'b0;
        calm    = 1'b0;

        while (chk_outstanding != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d commands and %0d result beats, %0d of them expiries",
                 chk_cmds, chk_beats, chk_expiries);
        $display("%0d mismatches found", chk_errors);
        if (chk_errors == 0)
            $display("** periodic_timer_table_unit: PASSED **");
        else
            $display("** periodic_timer_table_unit: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_alu.sv
hw/rtl/ptt_mem.sv
hw/rtl/periodic_timer_table_unit.sv
bench/ptt_checker.sv
bench/testbench.sv
